// ----- rtl/tcw_pkg.sv -----
// tcw_pkg: screen geometry, cell constants, op codes, controller states and
// the command and status bundles shared by the text console writer modules
// no dependencies
package tcw_pkg;

   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = COLS * ROWS;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int LIN_W  = 11;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] ATTR_RESET   = 8'h0F;

   typedef enum logic [2:0] {
      OP_PUT        = 3'd0,
      OP_BACKSPACE  = 3'd1,
      OP_CLEAR      = 3'd2,
      OP_SET_CURSOR = 3'd3,
      OP_READ_CELL  = 3'd4,
      OP_NEWLINE    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_PUT,
      ST_CLEAR,
      ST_SCROLL,
      ST_DRAIN
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INC_COL,
      CUR_DEC_COL,
      CUR_HOME,
      CUR_SET,
      CUR_NEWLINE
   } cur_act_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_PUT_CHAR,
      MEM_BLANK_PREV,
      MEM_READ_TARGET,
      MEM_INIT_FILL,
      MEM_CLEAR_FILL,
      MEM_SCROLL
   } mem_act_type;

   typedef struct packed {
      logic        load_req;
      cur_act_type cur_act;
      mem_act_type mem_act;
      logic        cnt_clr;
      logic        finish;
      logic        with_cell;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       is_newline;
      logic       wrap_pending;
      logic       last_row;
      logic       col_zero;
      logic       cnt_last;
      logic       rsp_free;
   } status_type;

   // row * COLS + col
   function automatic logic [LIN_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [LIN_W-1:0] base;
      base = LIN_W'(row) * LIN_W'(COLS);
      return base + LIN_W'(col);
   endfunction

endpackage

// ----- rtl/tcw_if.sv -----
// tcw_if: valid/ready channel interfaces for requests, responses and the
// attribute register write port; depends on tcw_pkg
interface tcw_req_if import tcw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [2:0]       op;
   logic [7:0]       char_code;
   logic [COL_W-1:0] target_col;
   logic [ROW_W-1:0] target_row;

   modport source (output valid, op, char_code, target_col, target_row, input ready);
   modport sink   (input valid, op, char_code, target_col, target_row, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] cursor_col;
   logic [ROW_W-1:0] cursor_row;
   logic [LIN_W-1:0] cursor_linear;
   logic [7:0]       cell_char;
   logic [7:0]       cell_attr;

   modport source (output valid, cursor_col, cursor_row, cursor_linear, cell_char,
                   cell_attr, input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_linear, cell_char,
                   cell_attr, output ready);
endinterface

interface tcw_csr_if ();
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/text_console_writer.sv -----
// text_console_writer: text console engine over an 80 x 25 cell screen
// depends on tcw_pkg, tcw_if, tcw_ctrl and tcw_datapath
//
//  channel   dir   beat carries
//  req_ch    in    op, char_code, target_col, target_row
//  rsp_ch    out   cursor_col, cursor_row, cursor_linear, cell_char, cell_attr
//  csr_ch    in    text attribute byte (always ready)
//
// one item in flight: each is accepted, then executed; read cell adds a wait
// state and a wrapping put a put state; clear sweeps all CELLS cells, and a
// scroll sweeps them, drains, then runs the put state if a wrapping put scrolls
// after reset a fill pass writes all CELLS cells before req_ch goes ready;
// csr beats are taken throughout
// a stalled response holds req_ch off until its beat is taken
module text_console_writer import tcw_pkg::*; (
   input logic       clock,
   input logic       reset,
   tcw_req_if.sink   req_ch,
   tcw_rsp_if.source rsp_ch,
   tcw_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   // attribute register never back-pressures
   assign csr_ch.ready = 1'b1;

   // sequencer: reset fill, op decode, scroll and clear sweeps
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // screen memory, cursor and response register
   tcw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_ch.op),
      .req_char_code     (req_ch.char_code),
      .req_target_col    (req_ch.target_col),
      .req_target_row    (req_ch.target_row),
      .csr_valid         (csr_ch.valid),
      .csr_data          (csr_ch.data),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_cursor_col    (rsp_ch.cursor_col),
      .rsp_cursor_row    (rsp_ch.cursor_row),
      .rsp_cursor_linear (rsp_ch.cursor_linear),
      .rsp_cell_char     (rsp_ch.cell_char),
      .rsp_cell_attr     (rsp_ch.cell_attr),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ----- rtl/tcw_ctrl.sv -----
// tcw_ctrl: sequencing state machine of the text console writer
// depends on tcw_pkg
module tcw_ctrl import tcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      pend_put_ff, pend_put_in;
   logic      nl_like;
   logic      wrap_put;

   // newline op or newline character; wrapping put also moves to the next line
   assign nl_like  = (status.op == OP_NEWLINE) ||
                     ((status.op == OP_PUT) && status.is_newline);
   assign wrap_put = (status.op == OP_PUT) && !status.is_newline && status.wrap_pending;

   assign req_ready = (state_ff == ST_IDLE) && status.rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         pend_put_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_put_ff <= pend_put_in;
      end
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      pend_put_in = pend_put_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (nl_like || wrap_put) begin
               if (status.last_row) begin
                  state_in    = ST_SCROLL;
                  pend_put_in = wrap_put;
               end else if (wrap_put) begin
                  state_in = ST_PUT;
               end
            end else if (status.op == OP_CLEAR) begin
               state_in = ST_CLEAR;
            end else if (status.op == OP_READ_CELL) begin
               state_in = ST_READ_WAIT;
            end
         end
         ST_READ_WAIT: state_in = ST_IDLE;
         ST_PUT:       state_in = ST_IDLE;
         ST_CLEAR: begin
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (status.cnt_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = pend_put_ff ? ST_PUT : ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.cur_act   = CUR_HOLD;
      cmd.mem_act   = MEM_NONE;
      cmd.load_req  = req_valid && req_ready;
      case (state_ff)
         ST_INIT: begin
            cmd.mem_act = MEM_INIT_FILL;
         end
         ST_IDLE: begin
         end
         ST_EXEC: begin
            if (nl_like || wrap_put) begin
               cmd.cur_act = CUR_NEWLINE;
               cmd.cnt_clr = status.last_row;
               cmd.finish  = nl_like && !status.last_row;
            end else begin
               case (status.op)
                  OP_PUT: begin
                     cmd.mem_act = MEM_PUT_CHAR;
                     cmd.cur_act = CUR_INC_COL;
                     cmd.finish  = 1'b1;
                  end
                  OP_BACKSPACE: begin
                     if (!status.col_zero) begin
                        cmd.cur_act = CUR_DEC_COL;
                        cmd.mem_act = MEM_BLANK_PREV;
                     end
                     cmd.finish = 1'b1;
                  end
                  OP_CLEAR: begin
                     cmd.cur_act = CUR_HOME;
                     cmd.cnt_clr = 1'b1;
                  end
                  OP_SET_CURSOR: begin
                     cmd.cur_act = CUR_SET;
                     cmd.finish  = 1'b1;
                  end
                  OP_READ_CELL: begin
                     cmd.mem_act = MEM_READ_TARGET;
                  end
                  default: begin
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            cmd.finish    = 1'b1;
            cmd.with_cell = 1'b1;
         end
         ST_PUT: begin
            cmd.mem_act = MEM_PUT_CHAR;
            cmd.cur_act = CUR_INC_COL;
            cmd.finish  = 1'b1;
         end
         ST_CLEAR: begin
            cmd.mem_act = MEM_CLEAR_FILL;
            cmd.finish  = status.cnt_last;
         end
         ST_SCROLL: begin
            cmd.mem_act = MEM_SCROLL;
         end
         ST_DRAIN: begin
            cmd.finish = !pend_put_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/tcw_datapath.sv -----
// tcw_datapath: screen memory, cursor, attribute register, sweep counter
// and response register; depends on tcw_pkg
module tcw_datapath import tcw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       req_op,
   input  logic [7:0]       req_char_code,
   input  logic [COL_W-1:0] req_target_col,
   input  logic [ROW_W-1:0] req_target_row,
   input  logic             csr_valid,
   input  logic [7:0]       csr_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [COL_W-1:0] rsp_cursor_col,
   output logic [ROW_W-1:0] rsp_cursor_row,
   output logic [LIN_W-1:0] rsp_cursor_linear,
   output logic [7:0]       rsp_cell_char,
   output logic [7:0]       rsp_cell_attr,
   input  cmd_type          cmd,
   output status_type       status
);

   logic [15:0]       mem_q [CELLS];

   logic [2:0]        op_ff;
   logic [7:0]        char_ff;
   logic [COL_W-1:0]  tcol_ff, tcol_in;
   logic [ROW_W-1:0]  trow_ff, trow_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [7:0]        attr_ff;
   logic [ADDR_W-1:0] cnt_ff;
   logic              pw_en_ff;
   logic [ADDR_W-1:0] pw_addr_ff;
   logic              pw_from_mem_ff;
   logic [15:0]       rd_q_ff;
   logic              rsp_valid_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [LIN_W-1:0]  rsp_lin_ff;
   logic [15:0]       rsp_cell_ff;

   logic              last_row;
   logic              src_in_range;
   logic [ADDR_W-1:0] cur_addr;
   logic [15:0]       blank;
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [15:0]       wd;
   logic              re;
   logic [ADDR_W-1:0] ra;
   logic              sweep;

   assign last_row     = (row_ff == ROW_W'(ROWS - 1));
   assign src_in_range = (cnt_ff < ADDR_W'(CELLS - COLS));
   assign cur_addr     = ADDR_W'(cell_index(row_ff, col_ff));
   assign blank        = {attr_ff, BLANK_CHAR};
   assign sweep        = (cmd.mem_act == MEM_INIT_FILL) || (cmd.mem_act == MEM_CLEAR_FILL) ||
                         (cmd.mem_act == MEM_SCROLL);

   // targets saturate at the screen edge
   assign tcol_in = (req_target_col > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : req_target_col;
   assign trow_in = (req_target_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : req_target_row;

   always_comb begin
      status              = '0;
      status.op           = op_ff;
      status.is_newline   = (char_ff == NEWLINE_CHAR);
      status.wrap_pending = (col_ff >= COL_W'(COLS));
      status.last_row     = last_row;
      status.col_zero     = (col_ff == '0);
      status.cnt_last     = (cnt_ff == ADDR_W'(CELLS - 1));
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // cursor update
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (cmd.cur_act)
         CUR_INC_COL: col_in = col_ff + 1'b1;
         CUR_DEC_COL: col_in = col_ff - 1'b1;
         CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         CUR_SET: begin
            col_in = tcol_ff;
            row_in = trow_ff;
         end
         CUR_NEWLINE: begin
            col_in = '0;
            if (!last_row) row_in = row_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // single write port; the delayed scroll write owns it while active
   always_comb begin
      we = 1'b0;
      wa = cur_addr;
      wd = blank;
      if (pw_en_ff) begin
         we = 1'b1;
         wa = pw_addr_ff;
         wd = pw_from_mem_ff ? rd_q_ff : blank;
      end else begin
         case (cmd.mem_act)
            MEM_PUT_CHAR: begin
               we = 1'b1;
               wd = {attr_ff, char_ff};
            end
            MEM_BLANK_PREV: begin
               we = 1'b1;
               wa = cur_addr - 1'b1;
            end
            MEM_INIT_FILL: begin
               we = 1'b1;
               wa = cnt_ff;
               wd = {ATTR_RESET, BLANK_CHAR};
            end
            MEM_CLEAR_FILL: begin
               we = 1'b1;
               wa = cnt_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // read port: target cell or the scroll source one row below
   always_comb begin
      re = 1'b0;
      ra = ADDR_W'(cell_index(trow_ff, tcol_ff));
      case (cmd.mem_act)
         MEM_READ_TARGET: re = 1'b1;
         MEM_SCROLL: begin
            re = src_in_range;
            ra = cnt_ff + ADDR_W'(COLS);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem_q[wa] <= wd;
      if (re) rd_q_ff <= mem_q[ra];
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         cnt_ff       <= '0;
         pw_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         pw_en_ff <= (cmd.mem_act == MEM_SCROLL);
         if (csr_valid) attr_ff <= csr_data;
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (sweep) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         char_ff <= req_char_code;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
      end
      pw_addr_ff     <= cnt_ff;
      pw_from_mem_ff <= src_in_range;
      if (cmd.finish) begin
         rsp_col_ff  <= col_in;
         rsp_row_ff  <= row_in;
         rsp_lin_ff  <= cell_index(row_in, col_in);
         rsp_cell_ff <= cmd.with_cell ? rd_q_ff : 16'h0000;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_cell_char     = rsp_cell_ff[7:0];
   assign rsp_cell_attr     = rsp_cell_ff[15:8];

endmodule

// ----- verif/tb_text_console_writer.sv -----
// tb_text_console_writer: self-checking bench for the text console writer,
// an opening command table then randomised traffic under several idling mixes
// depends on tcw_pkg, the tcw_if channel interfaces and text_console_writer
module tb_text_console_writer;
   import tcw_pkg::*;

   // op codes that the block has no operation for
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // longest correct quiet spell is the reset fill or a clear/scroll walk over
   // all CELLS cells, plus a stalled response
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASES         = 5;

   // one response beat as the bench expects it
   typedef struct packed {
      logic [COL_W-1:0] cur_col;
      logic [ROW_W-1:0] cur_row;
      logic [LIN_W-1:0] cur_lin;
      logic [7:0]       cell_ch;
      logic [7:0]       cell_at;
   } cursor_report_type;

   localparam cursor_report_type NO_REPORT = '0;

   // one row of the opening table; typed rows carry their own expectation
   typedef struct {
      logic [2:0]        op;
      logic [7:0]        ch;
      logic [COL_W-1:0]  tc;
      logic [ROW_W-1:0]  tr;
      bit                typed;
      cursor_report_type rpt;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();
   tcw_csr_if csr_ch ();

   text_console_writer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // 10 unit period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of the console: screen, cursor and attribute register
   logic [15:0]      model_screen [CELLS];
   logic [COL_W-1:0] model_col;
   logic [ROW_W-1:0] model_row;
   logic [7:0]       model_attr;

   cursor_report_type expected_reports [$];
   stim_row_type      opening_rows [$];

   int mismatches     = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int phase_items [PHASES] = '{300, 300, 300, 300, 325};
   int phase_send  [PHASES] = '{0, 51, 0, 28, 0};
   int phase_recv  [PHASES] = '{0, 0, 51, 28, 0};

   function automatic cursor_report_type make_report(int col, int row, int ch, int at);
      cursor_report_type r;
      r.cur_col = COL_W'(col);
      r.cur_row = ROW_W'(row);
      r.cur_lin = LIN_W'(row * COLS + col);
      r.cell_ch = 8'(ch);
      r.cell_at = 8'(at);
      return r;
   endfunction

   function void model_reset();
      for (int i = 0; i < CELLS; i++)
         model_screen[i] = {ATTR_RESET, BLANK_CHAR};
      model_col  = '0;
      model_row  = '0;
      model_attr = ATTR_RESET;
   endfunction

   // carriage return plus line feed; on the bottom row everything moves up
   // one row and the bottom row is blanked in the current attribute
   function void model_line_feed();
      model_col = '0;
      if (model_row < ROWS - 1) begin
         model_row = model_row + 1'b1;
      end else begin
         for (int i = 0; i < CELLS - COLS; i++)
            model_screen[i] = model_screen[i + COLS];
         for (int i = 0; i < COLS; i++)
            model_screen[(ROWS - 1) * COLS + i] = {model_attr, BLANK_CHAR};
      end
   endfunction

   // apply one command to the bench copy and return the response it gives
   function cursor_report_type console_step(logic [2:0] op, logic [7:0] ch,
                                            logic [COL_W-1:0] tc, logic [ROW_W-1:0] tr);
      cursor_report_type r;
      int col_t;
      int row_t;
      int idx;
      col_t = (tc > COLS - 1) ? COLS - 1 : int'(tc);
      row_t = (tr > ROWS - 1) ? ROWS - 1 : int'(tr);
      r = '0;
      case (op)
         OP_PUT: begin
            if (ch == NEWLINE_CHAR) begin
               model_line_feed();
            end else begin
               if (model_col >= COLS)
                  model_line_feed();
               model_screen[model_row * COLS + model_col] = {model_attr, ch};
               model_col = model_col + 1'b1;
            end
         end
         OP_BACKSPACE: begin
            if (model_col != 0) begin
               model_col = model_col - 1'b1;
               model_screen[model_row * COLS + model_col] = {model_attr, BLANK_CHAR};
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               model_screen[i] = {model_attr, BLANK_CHAR};
            model_col = '0;
            model_row = '0;
         end
         OP_SET_CURSOR: begin
            model_col = COL_W'(col_t);
            model_row = ROW_W'(row_t);
         end
         OP_READ_CELL: begin
            idx = row_t * COLS + col_t;
            r.cell_ch = model_screen[idx][7:0];
            r.cell_at = model_screen[idx][15:8];
         end
         OP_NEWLINE: model_line_feed();
         default: ;
      endcase
      r.cur_col = model_col;
      r.cur_row = model_row;
      r.cur_lin = LIN_W'(model_row * COLS + model_col);
      return r;
   endfunction

   task automatic add_row(input logic [2:0] op, input logic [7:0] ch,
                          input logic [COL_W-1:0] tc, input logic [ROW_W-1:0] tr,
                          input bit typed, input cursor_report_type rpt);
      stim_row_type row;
      row.op    = op;
      row.ch    = ch;
      row.tc    = tc;
      row.tr    = tr;
      row.typed = typed;
      row.rpt   = rpt;
      opening_rows.push_back(row);
   endtask

   // one request beat; called just after a rising edge, returns at the edge
   // that took the beat so valid can stay high into the next one
   task automatic send_command(input logic [2:0] op, input logic [7:0] ch,
                               input logic [COL_W-1:0] tc, input logic [ROW_W-1:0] tr,
                               input bit typed, input cursor_report_type rpt);
      cursor_report_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.char_code  <= ch;
      req_ch.target_col <= tc;
      req_ch.target_row <= tr;
      do @(posedge clock); while (!req_ch.ready);
      predicted = console_step(op, ch, tc, tr);
      expected_reports.push_back(typed ? rpt : predicted);
   endtask

   // attribute register write, only with nothing in flight
   task automatic write_attribute(input logic [7:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      model_attr = value;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (expected_reports.size() != 0)
         @(posedge clock);
   endtask

   function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: rsp %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // response side: random back-pressure, every beat checked against the
   // oldest expectation
   always @(posedge clock) begin
      cursor_report_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: rsp beat with nothing expected, col %0d row %0d", $time,
                     rsp_ch.cursor_col, rsp_ch.cursor_row);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("cursor_col", 16'(want.cur_col), 16'(rsp_ch.cursor_col));
            check_field("cursor_row", 16'(want.cur_row), 16'(rsp_ch.cursor_row));
            check_field("cursor_linear", 16'(want.cur_lin), 16'(rsp_ch.cursor_linear));
            check_field("cell_char", 16'(want.cell_ch), 16'(rsp_ch.cell_char));
            check_field("cell_attr", 16'(want.cell_at), 16'(rsp_ch.cell_attr));
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: any beat on any channel counts as progress
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [2:0]       op;
      logic [7:0]       ch;
      logic [COL_W-1:0] tc;
      logic [ROW_W-1:0] tr;
      int               pick;
      int               shape;

      // every input known from time zero
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_PUT;
      req_ch.char_code  = '0;
      req_ch.target_col = '0;
      req_ch.target_row = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.data       = '0;
      model_reset();

      // opening table; screen starts blank in the reset attribute
      add_row(OP_READ_CELL, 8'h00, 7'd0, 5'd0, 1'b1, make_report(0, 0, 'h20, 'h0F));
      // target beyond the screen saturates to the bottom right cell
      add_row(OP_READ_CELL, 8'hFF, 7'd127, 5'd31, 1'b1, make_report(0, 0, 'h20, 'h0F));
      // backspace at column zero leaves everything alone
      add_row(OP_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b1, make_report(0, 0, 0, 0));
      add_row(OP_PUT, 8'h41, 7'd0, 5'd0, 1'b1, make_report(1, 0, 0, 0));
      add_row(OP_PUT, 8'hFF, 7'd127, 5'd31, 1'b1, make_report(2, 0, 0, 0));
      add_row(OP_PUT, 8'h00, 7'd0, 5'd0, 1'b1, make_report(3, 0, 0, 0));
      add_row(OP_READ_CELL, 8'h00, 7'd2, 5'd0, 1'b1, make_report(3, 0, 'h00, 'h0F));
      add_row(OP_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b1, make_report(2, 0, 0, 0));
      add_row(OP_READ_CELL, 8'h00, 7'd1, 5'd0, 1'b0, NO_REPORT);
      // character ten behaves as a newline
      add_row(OP_PUT, NEWLINE_CHAR, 7'd0, 5'd0, 1'b1, make_report(0, 1, 0, 0));
      add_row(OP_SET_CURSOR, 8'h00, 7'd79, 5'd0, 1'b1, make_report(79, 0, 0, 0));
      // last column written: wrap pending, column reads as COLS
      add_row(OP_PUT, 8'h7E, 7'd0, 5'd0, 1'b1, make_report(80, 0, 0, 0));
      add_row(OP_READ_CELL, 8'h00, 7'd79, 5'd0, 1'b0, NO_REPORT);
      // backspace with wrap pending steps back onto the last column
      add_row(OP_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b1, make_report(79, 0, 0, 0));
      add_row(OP_READ_CELL, 8'h00, 7'd79, 5'd0, 1'b0, NO_REPORT);
      add_row(OP_PUT, 8'h55, 7'd0, 5'd0, 1'b0, NO_REPORT);
      add_row(OP_PUT, 8'h56, 7'd0, 5'd0, 1'b0, NO_REPORT);
      add_row(OP_SET_CURSOR, 8'h00, 7'd127, 5'd31, 1'b1, make_report(79, 24, 0, 0));
      add_row(OP_PUT, 8'h58, 7'd0, 5'd0, 1'b0, NO_REPORT);
      // wrap on the bottom row scrolls the screen
      add_row(OP_PUT, 8'h59, 7'd0, 5'd0, 1'b0, NO_REPORT);
      add_row(OP_READ_CELL, 8'h00, 7'd79, 5'd23, 1'b0, NO_REPORT);
      add_row(OP_NEWLINE, 8'h00, 7'd0, 5'd0, 1'b1, make_report(0, 24, 0, 0));
      add_row(OP_PUT, NEWLINE_CHAR, 7'd0, 5'd0, 1'b1, make_report(0, 24, 0, 0));
      // unused op codes only report the cursor
      add_row(OP_SPARE_6, 8'hFF, 7'd127, 5'd31, 1'b1, make_report(0, 24, 0, 0));
      add_row(OP_SPARE_7, 8'h00, 7'd0, 5'd0, 1'b1, make_report(0, 24, 0, 0));
      add_row(OP_CLEAR, 8'h00, 7'd0, 5'd0, 1'b1, make_report(0, 0, 0, 0));
      add_row(OP_READ_CELL, 8'h00, 7'd40, 5'd12, 1'b1, make_report(0, 0, 'h20, 'h0F));

      // reset is held, then released so the block runs its fill pass
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         send_command(opening_rows[i].op, opening_rows[i].ch, opening_rows[i].tc,
                      opening_rows[i].tr, opening_rows[i].typed, opening_rows[i].rpt);

      for (int p = 0; p < PHASES; p++) begin
         // idle point: request valid down, every response back, then csr write
         req_ch.valid <= 1'b0;
         wait_for_drain();
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         if (p == 0)
            write_attribute(8'h00);
         else if (p == 1)
            write_attribute(8'hFF);
         else
            write_attribute(8'($urandom_range(255)));
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];

         for (int n = 0; n < phase_items[p]; n++) begin
            // unused fields carry noise over their full width
            ch   = 8'($urandom_range(255));
            tc   = COL_W'($urandom_range(127));
            tr   = ROW_W'($urandom_range(31));
            pick = $urandom_range(99);
            if (pick < 52)
               op = OP_PUT;
            else if (pick < 62)
               op = OP_BACKSPACE;
            else if (pick < 64)
               op = OP_CLEAR;
            else if (pick < 79)
               op = OP_SET_CURSOR;
            else if (pick < 92)
               op = OP_READ_CELL;
            else if (pick < 98)
               op = OP_NEWLINE;
            else
               op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;

            shape = $urandom_range(9);
            case (op)
               OP_PUT: begin
                  if ($urandom_range(49) == 0)
                     ch = NEWLINE_CHAR;
               end
               OP_SET_CURSOR: begin
                  // lean towards the right margin and the bottom row so that
                  // wraps and scrolls come often
                  if (shape == 1) begin
                     tc = COL_W'($urandom_range(79, 70));
                     tr = ROW_W'(ROWS - 1);
                  end else if (shape < 4) begin
                     tc = COL_W'($urandom_range(79, 76));
                     tr = ROW_W'($urandom_range(ROWS - 1));
                  end else if (shape != 0) begin
                     tc = COL_W'($urandom_range(COLS - 1));
                     tr = ROW_W'($urandom_range(ROWS - 1));
                  end
               end
               OP_READ_CELL: begin
                  // half the time read back near the cursor where text has landed
                  if (shape < 5) begin
                     tc = (model_col == 0) ? '0 : COL_W'(model_col - $urandom_range(1));
                     tr = model_row;
                  end else if (shape != 0) begin
                     tc = COL_W'($urandom_range(COLS - 1));
                     tr = ROW_W'($urandom_range(ROWS - 1));
                  end
               end
               default: ;
            endcase
            send_command(op, ch, tc, tr, 1'b0, NO_REPORT);
         end
      end

      req_ch.valid <= 1'b0;
      wait_for_drain();
      // a little longer to catch any stray response
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
